// ===== rtl/ccstd_pkg.sv =====
// Shared types, constants and divider helpers for the cyclic code syndrome table decoder.
// Used by ccstd_ctrl, ccstd_datapath and the top level; depends on nothing.
package ccstd_pkg;

  localparam int SYNDROME_BITS = 20;
  localparam int MAX_CODE_BITS = 31;

  localparam int GEN_W      = 21;
  localparam int CODE_LEN_W = 5;
  localparam int WORD_W     = 31;
  localparam int MSG_W      = 16;
  localparam int REM_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = GEN_W;
  localparam int IDX_W      = $clog2(MAX_CODE_BITS);
  localparam int DEG_W      = $clog2(GEN_W);

  localparam logic [GEN_W-1:0]      GEN_RESET     = 21'd1100603;
  localparam logic [CODE_LEN_W-1:0] CODE_LEN_RESET = 5'd31;

  localparam logic [CFG_IDX_W-1:0] REG_GENERATOR_POLY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_LENGTH    = 1'd1;

  localparam logic OP_MARK   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef struct packed {
    logic                     opcode;
    logic [SYNDROME_BITS-1:0] syndrome_value;
    logic [WORD_W-1:0]        code_word;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] corrected_word;
    logic [MSG_W-1:0]  message;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_en;
    logic mark_en;
    logic start;
    logic syn_step;
    logic cor_step;
    logic drain;
    logic quo_step;
    logic out_load;
  } ccstd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic n_zero;
    logic idx_zero;
  } ccstd_sts_t;

  typedef struct packed {
    logic             red;
    logic [REM_W-1:0] rem;
  } div_res_t;

  // Highest set bit of the generator; 0 for generators 0 and 1.
  function automatic logic [DEG_W-1:0] poly_degree(input logic [GEN_W-1:0] g);
    logic [DEG_W-1:0] d;
    d = '0;
    for (int k = 1; k < GEN_W; k++) begin
      if (g[k]) begin
        d = DEG_W'(k);
      end
    end
    return d;
  endfunction

  // One step of the polynomial divider.
  function automatic div_res_t div_step(input logic [REM_W-1:0] rem,
                                        input logic             bit_in,
                                        input logic [DEG_W-1:0] deg,
                                        input logic [GEN_W-1:0] g);
    div_res_t   res;
    logic [REM_W-1:0] r;
    r = {rem[REM_W-2:0], bit_in};
    res.red = r[deg];
    res.rem = res.red ? (r ^ REM_W'(g)) : r;
    return res;
  endfunction

endpackage

// ===== rtl/ccstd_datapath.sv =====
// Datapath: configuration registers, syndrome mark memory, shift divider, output register.
// Driven by ccstd_ctrl through ccstd_pkg::ccstd_cmd_t; uses ccstd_pkg.
module ccstd_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ccstd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ccstd_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  ccstd_pkg::in_item_t                 in_data_i,
  input  ccstd_pkg::ccstd_cmd_t               cmd_i,
  output ccstd_pkg::ccstd_sts_t               sts_o,
  output ccstd_pkg::out_item_t                out_data_o
);

  localparam int SB = ccstd_pkg::SYNDROME_BITS;

  logic [ccstd_pkg::GEN_W-1:0]      gen_q;
  logic [ccstd_pkg::CODE_LEN_W-1:0] len_q;
  logic [ccstd_pkg::CODE_LEN_W-1:0] n_eff;
  logic [SB-1:0]                    clr_addr_q;

  logic                             mark_mem_q [2**SB];
  logic                             mark_rd_q;
  logic                             mem_we;
  logic [SB-1:0]                    mem_waddr;

  logic [ccstd_pkg::DEG_W-1:0]      deg_q;
  logic [ccstd_pkg::GEN_W-1:0]      g_q;
  logic [ccstd_pkg::WORD_W-1:0]     word_q;
  logic [ccstd_pkg::WORD_W-1:0]     fixed_q, fixed_d;
  logic [ccstd_pkg::REM_W-1:0]      rem_q, rem_d;
  logic [ccstd_pkg::IDX_W-1:0]      idx_q, idx_d;
  logic [ccstd_pkg::MSG_W-1:0]      msg_q, msg_d;
  logic                             pend_valid_q;
  logic                             pend_nz_q;
  logic [ccstd_pkg::IDX_W-1:0]      pend_idx_q;
  logic                             div_bit;
  ccstd_pkg::div_res_t              step;
  ccstd_pkg::out_item_t             out_q;
  logic [ccstd_pkg::IDX_W-1:0]      idx_top;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= ccstd_pkg::GEN_RESET;
      len_q <= ccstd_pkg::CODE_LEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ccstd_pkg::REG_GENERATOR_POLY: gen_q <= cfg_wdata_i[ccstd_pkg::GEN_W-1:0];
        ccstd_pkg::REG_CODE_LENGTH:    len_q <= cfg_wdata_i[ccstd_pkg::CODE_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_eff = (len_q > ccstd_pkg::CODE_LEN_W'(ccstd_pkg::MAX_CODE_BITS))
               ? ccstd_pkg::CODE_LEN_W'(ccstd_pkg::MAX_CODE_BITS) : len_q;
  assign idx_top = ccstd_pkg::IDX_W'(n_eff - 1'b1);

  // Clearing pass address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear_en) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // Mark memory: one write port, one registered read port addressed by the remainder.
  assign mem_we    = cmd_i.clear_en | cmd_i.mark_en;
  assign mem_waddr = cmd_i.clear_en ? clr_addr_q : in_data_i.syndrome_value;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mark_mem_q[mem_waddr] <= cmd_i.mark_en;
    end
    mark_rd_q <= mark_mem_q[rem_q[SB-1:0]];
  end

  // Divider input: word bit, corrected bit, or zero during correction.
  always_comb begin
    div_bit = 1'b0;
    if (cmd_i.syn_step) begin
      div_bit = word_q[idx_q];
    end else if (cmd_i.quo_step) begin
      div_bit = fixed_q[idx_q];
    end
  end

  assign step = ccstd_pkg::div_step(rem_q, div_bit, deg_q, g_q);

  always_comb begin
    rem_d   = rem_q;
    idx_d   = idx_q;
    msg_d   = msg_q;
    fixed_d = fixed_q;
    if (cmd_i.start) begin
      rem_d   = '0;
      idx_d   = idx_top;
      msg_d   = '0;
      fixed_d = '0;
    end else if (cmd_i.drain) begin
      rem_d = '0;
      idx_d = idx_top;
    end else if (cmd_i.syn_step || cmd_i.cor_step || cmd_i.quo_step) begin
      rem_d = step.rem;
      // reload the bit index when the syndrome pass ends
      idx_d = (cmd_i.syn_step && idx_q == '0) ? idx_top : idx_q - 1'b1;
      if (cmd_i.quo_step) begin
        msg_d = {msg_q[ccstd_pkg::MSG_W-2:0], step.red};
      end
    end
    // apply the lookup issued in the previous correction cycle
    if (pend_valid_q) begin
      fixed_d[pend_idx_q] = word_q[pend_idx_q] ^ (pend_nz_q & mark_rd_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else begin
      pend_valid_q <= cmd_i.cor_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      word_q <= in_data_i.code_word;
      g_q    <= gen_q;
      deg_q  <= ccstd_pkg::poly_degree(gen_q);
    end
    rem_q      <= rem_d;
    idx_q      <= idx_d;
    msg_q      <= msg_d;
    fixed_q    <= fixed_d;
    pend_idx_q <= idx_q;
    pend_nz_q  <= (rem_q != '0);
    if (cmd_i.out_load) begin
      out_q.corrected_word <= fixed_q;
      out_q.message        <= msg_q;
    end
  end

  assign sts_o.clear_done = (clr_addr_q == {SB{1'b1}});
  assign sts_o.n_zero     = (n_eff == '0);
  assign sts_o.idx_zero   = (idx_q == '0);
  assign out_data_o       = out_q;

endmodule

// ===== rtl/ccstd_ctrl.sv =====
// Controller: sequences clearing, marking and the three shift passes of a decode.
// Drives ccstd_datapath through ccstd_pkg::ccstd_cmd_t; uses ccstd_pkg.
module ccstd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  in_opcode_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  ccstd_pkg::ccstd_sts_t sts_i,
  output ccstd_pkg::ccstd_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SYN,
    ST_COR,
    ST_DRAIN,
    ST_QUO,
    ST_HOLD
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   in_accept;
  logic   out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.clear_en = (state_q == ST_CLEAR);
    cmd_o.mark_en  = in_accept && (in_opcode_i == ccstd_pkg::OP_MARK);
    cmd_o.start    = in_accept && (in_opcode_i == ccstd_pkg::OP_DECODE);
    cmd_o.syn_step = (state_q == ST_SYN);
    cmd_o.cor_step = (state_q == ST_COR);
    cmd_o.drain    = (state_q == ST_DRAIN);
    cmd_o.quo_step = (state_q == ST_QUO);
    cmd_o.out_load = (state_q == ST_HOLD) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: if (sts_i.clear_done) state_q <= ST_IDLE;
        ST_IDLE: begin
          if (cmd_o.start) begin
            // empty word: skip straight to the result
            state_q <= sts_i.n_zero ? ST_HOLD : ST_SYN;
          end
        end
        ST_SYN:   if (sts_i.idx_zero) state_q <= ST_COR;
        ST_COR:   if (sts_i.idx_zero) state_q <= ST_DRAIN;
        ST_DRAIN: state_q <= ST_QUO;
        ST_QUO:   if (sts_i.idx_zero) state_q <= ST_HOLD;
        ST_HOLD:  if (out_free) state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_result_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !out_valid_q)
    else $error("result valid during clearing pass");

  a_one_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.clear_en, cmd_o.mark_en, cmd_o.start, cmd_o.syn_step,
              cmd_o.cor_step, cmd_o.drain, cmd_o.quo_step}))
    else $error("conflicting datapath commands");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load && out_valid_q |-> !out_stall_i)
    else $error("pending result overwritten");

  a_cor_follows_syn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SYN && sts_i.idx_zero |=> state_q == ST_COR)
    else $error("correction pass did not follow syndrome pass");

endmodule

// ===== rtl/cyclic_code_syndrome_table_decoder_unit.sv =====
// Cyclic code syndrome table decoder (Meggitt style) with a correctable-syndrome bitmap.
// Instantiates ccstd_ctrl and ccstd_datapath; uses ccstd_pkg.
//
// Input channel (in_valid_i / in_stall_o, payload in_data_i): an item with opcode
// OP_MARK sets one syndrome bit in the bitmap; no result beat.
// An item with opcode OP_DECODE yields one result beat on the output channel
// (out_valid_o / out_stall_i, payload out_data_o): corrected word and message.
// After acceptance a decode runs these steps in order, n being code_length:
// n divider shifts for the syndrome, n shifts for correction with one bitmap
// read each (the read is registered and applied in the next cycle), one drain
// step, n shifts for the quotient and the load of the result register. The next
// item is taken after that load; one item is in flight at a time.
// The finished result sits in an output register, so the next item is taken while
// it waits; a decode finishing while that register is still stalled holds until
// it frees. After reset the bitmap is swept clear, one entry per cycle, through all
// 2^SYNDROME_BITS entries (1048576), and in_stall_o stays high until then.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) are taken any cycle and
// must only be issued while the block is idle.
module cyclic_code_syndrome_table_decoder_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ccstd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ccstd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  ccstd_pkg::in_item_t              in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output ccstd_pkg::out_item_t             out_data_o
);

  ccstd_pkg::ccstd_cmd_t cmd;
  ccstd_pkg::ccstd_sts_t sts;

  ccstd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_opcode_i (in_data_i.opcode),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ccstd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule
